[hdl/rob_pkg.sv]
// Shared constants, register codes and controller/datapath interface types of the branch picker.
package rob_pkg;

    // Sizing of the entry list and the random word.
    localparam int MAX_BRANCHES = 16;
    localparam int RANDOM_WIDTH = 32;

    // Derived widths: entry index, live count (can hold MAX_BRANCHES), bit counter.
    localparam int IDX_W  = (MAX_BRANCHES > 1) ? $clog2(MAX_BRANCHES) : 1;
    localparam int LIVE_W = $clog2(MAX_BRANCHES + 1);
    localparam int RCNT_W = $clog2(RANDOM_WIDTH);

    // Field widths of the registers and results.
    localparam int ITER_W    = 16;
    localparam int BCNT_W    = 5;
    localparam int BR_W      = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRANCH_CNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_BRANCH = 2'd2;

    // One list entry.
    typedef struct packed {
        logic [IDX_W-1:0]  branch;
        logic [ITER_W-1:0] remaining;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_we;
        logic load_init;
        logic load_step;
        logic div_init;
        logic div_step;
        logic rd_pick;
        logic out_pick;
        logic out_exit;
        logic wb_dec;
        logic dec_live;
        logic sh_rd;
        logic sh_wr;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cfg_known;
        logic live_zero;
        logic load_done;
        logic div_done;
        logic used_up;
        logic shift_done;
    } dp_status_t;

endpackage

[hdl/rob_ctrl.sv]
// Sequencing state machine of the branch picker.
module rob_ctrl
    import rob_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       cfg_valid,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       cfg_ready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_INIT,
        ST_LOAD,
        ST_DIV,
        ST_READ,
        ST_PICK,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid && !start)
                begin
                    cmd.cfg_we = 1'b1;
                    if (status.cfg_known)
                    begin
                        state_next = ST_LOAD_INIT;
                    end
                end
                else if (start)
                begin
                    if (status.live_zero)
                    begin
                        cmd.out_exit = 1'b1;
                        state_next   = ST_LOAD_INIT;
                    end
                    else
                    begin
                        cmd.div_init = 1'b1;
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_LOAD_INIT:
            begin
                cmd.load_init = 1'b1;
                state_next    = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (status.load_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.load_step = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_pick = 1'b1;
                state_next  = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.out_pick = 1'b1;
                if (status.used_up)
                begin
                    cmd.dec_live = 1'b1;
                    state_next   = ST_SHIFT_RD;
                end
                else
                begin
                    cmd.wb_dec = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT_RD:
            begin
                if (status.shift_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = ST_SHIFT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    // State and registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg && !start;

endmodule

[hdl/rob_dp.sv]
// Datapath of the branch picker: registers, entry list, serial modulo unit and result registers.
module rob_dp
    import rob_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data,
    input  logic [RANDOM_WIDTH-1:0] random_value,
    output dp_status_t              status,
    output logic                    result_valid,
    output logic [BR_W-1:0]         chosen_branch,
    output logic                    round_done
);

    // Configuration registers.
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic [BR_W-1:0]   exit_reg, exit_next;

    // List control.
    logic [LIVE_W-1:0] live_reg, live_next;
    logic [LIVE_W-1:0] load_n_reg, load_n_next;
    logic [LIVE_W-1:0] idx_reg, idx_next;
    logic [LIVE_W-1:0] idx_inc;
    logic [LIVE_W-1:0] load_n;

    // Serial modulo unit.
    logic [RANDOM_WIDTH-1:0] dividend_reg, dividend_next;
    logic [LIVE_W-1:0]       rem_reg, rem_next;
    logic [LIVE_W-1:0]       divisor_reg, divisor_next;
    logic [RCNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [LIVE_W:0]         trial;

    // Result registers.
    logic            result_valid_reg, result_valid_next;
    logic [BR_W-1:0] chosen_reg, chosen_next;
    logic            done_reg, done_next;

    // Entry list memory.
    entry_t            entry_mem [MAX_BRANCHES];
    entry_t            rdata_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    entry_t            mem_wdata;

    assign idx_inc = idx_reg + 1'b1;

    // Number of entries a load puts in, saturated at the list depth.
    always_comb
    begin
        if (int'(bcnt_reg) > MAX_BRANCHES)
        begin
            load_n = LIVE_W'(MAX_BRANCHES);
        end
        else
        begin
            load_n = LIVE_W'(bcnt_reg);
        end
    end

    // Configuration writes.
    always_comb
    begin
        iter_next = iter_reg;
        bcnt_next = bcnt_reg;
        exit_next = exit_reg;
        if (cmd.cfg_we)
        begin
            case (cfg_index)
                REG_ITER_COUNT:  iter_next = cfg_data[ITER_W-1:0];
                REG_BRANCH_CNT:  bcnt_next = cfg_data[BCNT_W-1:0];
                REG_EXIT_BRANCH: exit_next = cfg_data[BR_W-1:0];
                default:         iter_next = iter_reg;
            endcase
        end
    end

    assign status.cfg_known = (cfg_index == REG_ITER_COUNT)
                           || (cfg_index == REG_BRANCH_CNT)
                           || (cfg_index == REG_EXIT_BRANCH);

    // Live count, load count and list walk index.
    always_comb
    begin
        live_next   = live_reg;
        load_n_next = load_n_reg;
        idx_next    = idx_reg;
        if (cmd.load_init)
        begin
            live_next   = load_n;
            load_n_next = load_n;
            idx_next    = '0;
        end
        if (cmd.dec_live)
        begin
            live_next = live_reg - 1'b1;
        end
        if (cmd.load_step || cmd.sh_wr)
        begin
            idx_next = idx_inc;
        end
        if (cmd.out_pick)
        begin
            idx_next = rem_reg;
        end
    end

    // One quotient bit per cycle of restoring division; only the remainder is kept.
    always_comb
    begin
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        bit_cnt_next  = bit_cnt_reg;
        trial         = {rem_reg, dividend_reg[RANDOM_WIDTH-1]};
        if (cmd.div_init)
        begin
            dividend_next = random_value;
            rem_next      = '0;
            divisor_next  = live_reg;
            bit_cnt_next  = '0;
        end
        else if (cmd.div_step)
        begin
            dividend_next = {dividend_reg[RANDOM_WIDTH-2:0], 1'b0};
            bit_cnt_next  = bit_cnt_reg + 1'b1;
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = LIVE_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = LIVE_W'(trial);
            end
        end
    end

    // Memory port selection: load, decrement write-back or shift down.
    always_comb
    begin
        mem_we    = cmd.load_step || cmd.wb_dec || cmd.sh_wr;
        mem_waddr = idx_reg[IDX_W-1:0];
        mem_wdata = rdata_reg;
        if (cmd.load_step)
        begin
            mem_wdata.branch    = idx_reg[IDX_W-1:0];
            mem_wdata.remaining = iter_reg;
        end
        else if (cmd.wb_dec)
        begin
            mem_waddr           = rem_reg[IDX_W-1:0];
            mem_wdata.remaining = rdata_reg.remaining - 1'b1;
        end
        if (cmd.sh_rd)
        begin
            mem_raddr = idx_inc[IDX_W-1:0];
        end
        else
        begin
            mem_raddr = rem_reg[IDX_W-1:0];
        end
    end

    // Result beat.
    always_comb
    begin
        result_valid_next = cmd.out_pick || cmd.out_exit;
        chosen_next       = chosen_reg;
        done_next         = done_reg;
        if (cmd.out_pick)
        begin
            chosen_next = BR_W'(rdata_reg.branch);
            done_next   = 1'b0;
        end
        else if (cmd.out_exit)
        begin
            chosen_next = exit_reg;
            done_next   = 1'b1;
        end
    end

    // Status back to the controller.
    assign status.live_zero  = (live_reg == '0);
    assign status.load_done  = (idx_reg == load_n_reg);
    assign status.div_done   = (bit_cnt_reg == RCNT_W'(RANDOM_WIDTH - 1));
    assign status.used_up    = (rdata_reg.remaining <= ITER_W'(1));
    assign status.shift_done = (idx_reg == live_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg         <= ITER_W'(1);
            bcnt_reg         <= '0;
            exit_reg         <= '0;
            live_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            iter_reg         <= iter_next;
            bcnt_reg         <= bcnt_next;
            exit_reg         <= exit_next;
            live_reg         <= live_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        load_n_reg   <= load_n_next;
        idx_reg      <= idx_next;
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        bit_cnt_reg  <= bit_cnt_next;
        chosen_reg   <= chosen_next;
        done_reg     <= done_next;
    end

    // Entry list: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= entry_mem[mem_raddr];
    end

    assign result_valid  = result_valid_reg;
    assign chosen_branch = chosen_reg;
    assign round_done    = done_reg;

endmodule

[hdl/random_order_branch_picker_core.sv]
// Top level of the random order branch picker: controller and datapath.
//
// Each start beat draws one branch from the list without replacement and
// returns one result beat; result_valid is high for exactly one cycle and
// the receiver cannot stall it. A pick runs the one-bit-per-cycle remainder
// unit over the 32-bit random word, then reads the list and registers the
// result. When an entry is used up, every later entry is shifted down one
// place, read and then written back through the list's single write port.
// A start on an empty list returns exit_branch with round_done on the next
// cycle and then refills the list, one entry per cycle, with the loaded
// entry count (branch_count saturated at the list depth). Every accepted
// configuration write to a known register reloads the list the same way,
// and cfg_ready stays low while busy is high.
module random_order_branch_picker_core
    import rob_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [RANDOM_WIDTH-1:0] random_value,
    output logic                    result_valid,
    output logic [BR_W-1:0]         chosen_branch,
    output logic                    round_done,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    rob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_ready (cfg_ready)
    );

    // List, modulo unit and result registers.
    rob_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .random_value  (random_value),
        .status        (status),
        .result_valid  (result_valid),
        .chosen_branch (chosen_branch),
        .round_done    (round_done)
    );

endmodule

[sim/rob_checker.sv]
`timescale 1ns / 100ps
// Checker of the branch picker: mirrors the entry list, predicts every pick and compares results.
module rob_checker
    import rob_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [RANDOM_WIDTH-1:0] random_value,
    input  logic                    result_valid,
    input  logic [BR_W-1:0]         chosen_branch,
    input  logic                    round_done,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DAT_W-1:0]    cfg_data,
    output int                      fail_count,
    output int                      awaited
);

    // One predicted result beat.
    typedef struct packed {
        logic [BR_W-1:0] branch;
        logic            done;
    } pick_t;

    // Shadow copies of the registers and the entry list.
    logic [ITER_W-1:0] iter_reg;
    logic [BCNT_W-1:0] bcnt_reg;
    logic [BR_W-1:0]   exit_reg;
    logic [IDX_W-1:0]  list_branch [MAX_BRANCHES];
    logic [ITER_W-1:0] list_left   [MAX_BRANCHES];
    int                live;

    // Picks accepted on the start side whose result beat has not come yet.
    pick_t awaited_picks [$];

    // Load branches 0 .. count-1 with the current use count; the count saturates at the depth.
    task automatic refill_list();
        int n;
        n = (bcnt_reg > MAX_BRANCHES) ? MAX_BRANCHES : int'(bcnt_reg);
        for (int i = 0; i < n; i++)
        begin
            list_branch[i] = IDX_W'(i);
            list_left[i]   = iter_reg;
        end
        live = n;
    endtask

    // Apply one accepted register write; an unknown index leaves the list alone.
    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_ITER_COUNT:
            begin
                iter_reg = data[ITER_W-1:0];
                refill_list();
            end
            REG_BRANCH_CNT:
            begin
                bcnt_reg = data[BCNT_W-1:0];
                refill_list();
            end
            REG_EXIT_BRANCH:
            begin
                exit_reg = data[BR_W-1:0];
                refill_list();
            end
            default: ;
        endcase
    endtask

    // Draw one entry without replacement, or close the round when the list is empty.
    task automatic draw_branch(input logic [RANDOM_WIDTH-1:0] rnd, output pick_t res);
        int slot;
        if (live != 0)
        begin
            slot = int'(rnd % RANDOM_WIDTH'(live));
            res.branch = BR_W'(list_branch[slot]);
            res.done   = 1'b0;
            // A used-up entry (zero uses counts as one) leaves, later entries shift down.
            if (list_left[slot] <= 1)
            begin
                for (int i = slot; i + 1 < live; i++)
                begin
                    list_branch[i] = list_branch[i + 1];
                    list_left[i]   = list_left[i + 1];
                end
                live = live - 1;
            end
            else
            begin
                list_left[slot] = list_left[slot] - 1'b1;
            end
        end
        else
        begin
            refill_list();
            res.branch = exit_reg;
            res.done   = 1'b1;
        end
    endtask

    // Watch both channels at every edge; results are checked before new picks are queued.
    always @(posedge clk or negedge rst_n)
    begin
        pick_t want;
        if (!rst_n)
        begin
            iter_reg   = ITER_W'(1);
            bcnt_reg   = '0;
            exit_reg   = '0;
            live       = 0;
            fail_count = 0;
            awaited    = 0;
            awaited_picks.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (awaited_picks.size() == 0)
                begin
                    $display("%0t: result beat with no pick awaited: branch %0d done %0b",
                             $time, chosen_branch, round_done);
                    fail_count++;
                end
                else
                begin
                    want = awaited_picks.pop_front();
                    if (chosen_branch !== want.branch)
                    begin
                        $display("%0t: chosen_branch expected %0d actual %0d",
                                 $time, want.branch, chosen_branch);
                        fail_count++;
                    end
                    if (round_done !== want.done)
                    begin
                        $display("%0t: round_done expected %0b actual %0b",
                                 $time, want.done, round_done);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (start && !busy)
            begin
                draw_branch(random_value, want);
                awaited_picks.insert(awaited_picks.size(), want);
            end
            awaited = awaited_picks.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Top of the branch picker testbench: clock, reset, stimulus and the verdict.
module testbench;
    import rob_pkg::*;

    localparam int NUM_ITEMS    = 1550;
    localparam int DRAIN_CYCLES = 80;
    // Index beyond the three registers: accepted but ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    start        = 1'b0;
    logic [RANDOM_WIDTH-1:0] random_value = '0;
    logic                    cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index    = '0;
    logic [CFG_DAT_W-1:0]    cfg_data     = '0;
    logic                    busy;
    logic                    result_valid;
    logic [BR_W-1:0]         chosen_branch;
    logic                    round_done;
    logic                    cfg_ready;
    int                      fail_count;
    int                      awaited;

    int items_sent = 0;
    bit no_idle    = 1'b0;

    random_order_branch_picker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .random_value  (random_value),
        .result_valid  (result_valid),
        .chosen_branch (chosen_branch),
        .round_done    (round_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rob_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .random_value  (random_value),
        .result_valid  (result_valid),
        .chosen_branch (chosen_branch),
        .round_done    (round_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .awaited       (awaited)
    );

    always #5 clk = ~clk;

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Idle length between beats: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random word with extra weight on the extremes and on small values.
    function automatic logic [RANDOM_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return RANDOM_WIDTH'($urandom_range(0, 40));
            3:       return RANDOM_WIDTH'(1) << $urandom_range(0, RANDOM_WIDTH - 1);
            default: return RANDOM_WIDTH'($urandom());
        endcase
    endfunction

    // Send one pick beat; random_value wanders while start is low.
    task automatic send_pick(input logic [RANDOM_WIDTH-1:0] rnd);
        int gap;
        gap = no_idle ? 0 : gap_len();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
            begin
                random_value <= RANDOM_WIDTH'($urandom());
                @(posedge clk);
            end
        end
        start        <= 1'b1;
        random_value <= rnd;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    // Write one register once every awaited pick has come back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        start <= 1'b0;
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
        @(posedge clk);
        if (!no_idle)
            repeat (gap_len()) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Directed part: reset state, register extremes and each special case.
    task automatic directed_items();
        // Reset values leave the list empty, so every pick closes an empty round.
        send_pick('0);
        send_pick('1);
        // Two branches; a write to the unknown index must not reload the list.
        write_reg(REG_BRANCH_CNT, 16'd2);
        send_pick('1);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_pick('0);
        send_pick('0);
        // Zero uses count as one; upper data bits of the count and exit fields are dropped.
        write_reg(REG_ITER_COUNT, 16'd0);
        write_reg(REG_BRANCH_CNT, 16'hFFE3);
        write_reg(REG_EXIT_BRANCH, 16'hABFF);
        repeat (4) send_pick(rand_word());
        // Branch count above the depth saturates; longest use count.
        write_reg(REG_BRANCH_CNT, 16'd31);
        write_reg(REG_ITER_COUNT, 16'hFFFF);
        send_pick('1);
        send_pick(32'h8000_0000);
        send_pick(32'h7FFF_FFFF);
        send_pick(32'd15);
        // A single branch taken twice, then the round closes with exit zero.
        write_reg(REG_EXIT_BRANCH, 16'd0);
        write_reg(REG_BRANCH_CNT, 16'd1);
        write_reg(REG_ITER_COUNT, 16'd2);
        repeat (3) send_pick(rand_word());
        // No branches at all: each pick is an empty round.
        write_reg(REG_BRANCH_CNT, 16'd0);
        repeat (2) send_pick(rand_word());
    endtask

    // One random setting followed by about one or two full rounds of picks, or a shorter run when rounds are long.
    task automatic random_phase();
        logic [CFG_IDX_W-1:0] regs [3];
        logic [CFG_DAT_W-1:0] vals [3];
        int rot, eff_bc, eff_iter, round_len, n_items;

        // Use count: mostly small, sometimes zero, the maximum or medium sized.
        case ($urandom_range(0, 9))
            0:       vals[0] = 16'd0;
            1:       vals[0] = 16'hFFFF;
            2:       vals[0] = CFG_DAT_W'($urandom_range(5, 300));
            default: vals[0] = CFG_DAT_W'($urandom_range(1, 4));
        endcase
        // Branch count with random bits above the field.
        vals[1] = CFG_DAT_W'($urandom());
        case ($urandom_range(0, 9))
            0:       vals[1][BCNT_W-1:0] = '0;
            1:       vals[1][BCNT_W-1:0] = BCNT_W'($urandom_range(17, 31));
            2:       vals[1][BCNT_W-1:0] = BCNT_W'(16);
            default: vals[1][BCNT_W-1:0] = BCNT_W'($urandom_range(1, 15));
        endcase
        vals[2] = CFG_DAT_W'($urandom());
        regs[0] = REG_ITER_COUNT;
        regs[1] = REG_BRANCH_CNT;
        regs[2] = REG_EXIT_BRANCH;

        no_idle = ($urandom_range(0, 3) == 0);

        // Write all three registers in a rotated order, sometimes with an ignored write.
        rot = $urandom_range(0, 2);
        for (int j = 0; j < 3; j++)
        begin
            write_reg(regs[(rot + j) % 3], vals[(rot + j) % 3]);
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, CFG_DAT_W'($urandom()));
        end

        // Size the phase from the effective round length.
        eff_bc    = (vals[1][BCNT_W-1:0] > MAX_BRANCHES) ? MAX_BRANCHES
                                                         : int'(vals[1][BCNT_W-1:0]);
        eff_iter  = (vals[0] == 0) ? 1 : int'(vals[0]);
        round_len = eff_bc * eff_iter + 1;
        if (round_len > 120)
            n_items = $urandom_range(10, 60);
        else
            n_items = round_len * $urandom_range(1, 2) + $urandom_range(0, 3);

        for (int k = 0; k < n_items && items_sent < NUM_ITEMS; k++)
            send_pick(rand_word());
    endtask

    // Reset, directed part, random phases, then drain and report.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        directed_items();
        while (items_sent < NUM_ITEMS)
            random_phase();
        start <= 1'b0;
        @(negedge clk);
        while (awaited != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
